@@ design/bfa_pkg.sv @@
// shared types, field widths and codes for the bitmap frame allocator
package bfa_pkg;

  localparam int FRAME_W       = 10;
  localparam int CFG_W         = 11;
  localparam int STATUS_W      = 2;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 16;
  localparam int MAX_FRAMES_DEF = 1024;
  localparam int WORD_BITS_DEF  = 32;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 11'd1024;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC = 2'd0,
    ST_FREED = 2'd1,
    ST_NOOP  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    logic    start;
    logic    clr;
    logic    rd;
    logic    adv;
    logic    chk;
    logic    alloc_wr;
    logic    free_wr;
    logic    res_ld;
    status_t res_sel;
    logic    out_ld;
  } bfa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_noop;
    logic req_free;
    logic free_in_range;
    logic scan_ok;
    logic chk_vld;
    logic chk_hit;
    logic free_hit;
    logic out_free;
  } bfa_stat_t;

endpackage

@@ design/bfa_ctrl.sv @@
// controller state machine sequencing clear, scan, free and response
module bfa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  bfa_pkg::bfa_stat_t  st,
  output bfa_pkg::bfa_cmd_t   cmd
);
  import bfa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_SCAN,
    S_FSRCH,
    S_FWR,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        cmd.adv = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.start = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (st.req_noop) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = ST_NOOP;
          state_nxt   = S_RESP;
        end else if (!st.req_free) begin
          state_nxt = S_SCAN;
        end else if (!st.free_in_range) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = ST_FREED;
          state_nxt   = S_RESP;
        end else begin
          state_nxt = S_FSRCH;
        end
      end
      S_SCAN: begin
        if (st.chk_hit) begin
          cmd.alloc_wr = 1'b1;
          cmd.res_ld   = 1'b1;
          cmd.res_sel  = ST_ALLOC;
          state_nxt    = S_RESP;
        end else if (st.scan_ok) begin
          cmd.rd  = 1'b1;
          cmd.adv = 1'b1;
          cmd.chk = 1'b1;
        end else if (!st.chk_vld) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = ST_FULL;
          state_nxt   = S_RESP;
        end
      end
      S_FSRCH: begin
        if (st.free_hit) begin
          cmd.rd    = 1'b1;
          state_nxt = S_FWR;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      S_FWR: begin
        cmd.free_wr = 1'b1;
        cmd.res_ld  = 1'b1;
        cmd.res_sel = ST_FREED;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_tready = in_tready_r;

endmodule

@@ design/bfa_dp.sv @@
// datapath: bitmap ram, word scan counters, request, result and output registers
module bfa_dp #(
  parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF,
  parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bfa_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic [bfa_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bfa_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [bfa_pkg::STATUS_W-1:0]    out_tuser,
  input  bfa_pkg::bfa_cmd_t               cmd,
  output bfa_pkg::bfa_stat_t              st
);
  import bfa_pkg::*;

  localparam int NWORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CNT_W  = $clog2(NWORDS + 1);
  localparam int BW     = $clog2(WORD_BITS);
  localparam int AW     = $clog2(MAX_FRAMES + 2 * WORD_BITS + 1);
  localparam int VW0    = (AW > CFG_W) ? AW : CFG_W;
  localparam int VW     = (VW0 > FRAME_W) ? VW0 : FRAME_W;
  localparam int LIMIT_RST_I = (int'(FRAME_COUNT_RST) > MAX_FRAMES) ?
                               MAX_FRAMES : int'(FRAME_COUNT_RST);
  localparam int PAD_W  = OUT_DATA_W - FRAME_W - 3;

  localparam logic [VW-1:0]    MAXF      = VW'(MAX_FRAMES);
  localparam logic [VW-1:0]    WB_V      = VW'(WORD_BITS);
  localparam logic [VW-1:0]    LIMIT_RST = VW'(LIMIT_RST_I);
  localparam logic [CNT_W-1:0] LAST_WORD = CNT_W'(NWORDS - 1);

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [WORD_BITS-1:0] rdata_r;

  logic [CNT_W-1:0] addr_r;
  logic [VW-1:0]    base_r;
  logic             chk_vld_r;
  logic [CNT_W-1:0] chk_addr_r;
  logic [VW-1:0]    chk_base_r;
  logic [VW-1:0]    limit_r;
  logic [BW-1:0]    bit_r;

  op_t              req_op_r;
  logic [FRAME_W-1:0] req_cur_r;
  logic             req_sup_r;
  logic             req_wr_r;

  logic [FRAME_W-1:0] res_frame_r;
  logic             res_present_r;
  logic             res_writable_r;
  logic             res_user_r;
  status_t          res_status_r;

  logic             out_tvalid_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic             out_present_r;
  logic             out_writable_r;
  logic             out_user_r;
  status_t          out_status_r;

  logic [VW-1:0]        cur_v;
  logic [VW-1:0]        cfg_v;
  logic [VW-1:0]        limit_nxt;
  logic [VW-1:0]        base_end;
  logic [VW-1:0]        bit_off;
  logic [VW-1:0]        found_frame;
  logic [WORD_BITS-1:0] zero_1h;
  logic [BW-1:0]        zero_idx;
  logic [WORD_BITS-1:0] free_mask;

  assign cur_v     = VW'(req_cur_r);
  assign cfg_v     = VW'(cfg_wr_data);
  assign limit_nxt = (cfg_v > MAXF) ? MAXF : cfg_v;
  assign base_end  = base_r + WB_V;
  assign bit_off   = cur_v - base_r;
  assign free_mask = WORD_BITS'(1) << bit_r;

  // lowest clear bit of the checked word, one-hot then encoded
  assign zero_1h = ~rdata_r & (rdata_r + WORD_BITS'(1));

  always_comb begin
    zero_idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      zero_idx = zero_idx | (zero_1h[b] ? BW'(b) : BW'(0));
    end
  end

  assign found_frame = chk_base_r + VW'(zero_idx);

  always_comb begin
    st               = '0;
    st.clr_last      = (addr_r == LAST_WORD);
    st.req_noop      = ((req_op_r == OP_ALLOC) && (req_cur_r != '0)) ||
                       ((req_op_r == OP_FREE) && (req_cur_r == '0));
    st.req_free      = (req_op_r == OP_FREE);
    st.free_in_range = (cur_v < MAXF);
    st.scan_ok       = (base_end <= limit_r);
    st.chk_vld       = chk_vld_r;
    st.chk_hit       = chk_vld_r && (rdata_r != '1);
    st.free_hit      = (cur_v < base_end);
    st.out_free      = !out_tvalid_r || out_tready;
  end

  // bitmap ram, one read and one write port
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= mem[addr_r[ADDR_W-1:0]];
    end
    if (cmd.clr) begin
      mem[addr_r[ADDR_W-1:0]] <= '0;
    end else if (cmd.alloc_wr) begin
      mem[chk_addr_r[ADDR_W-1:0]] <= rdata_r | zero_1h;
    end else if (cmd.free_wr) begin
      mem[addr_r[ADDR_W-1:0]] <= rdata_r & ~free_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r       <= '0;
      base_r       <= '0;
      chk_vld_r    <= 1'b0;
      limit_r      <= LIMIT_RST;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        addr_r <= '0;
        base_r <= '0;
      end else if (cmd.adv) begin
        addr_r <= addr_r + CNT_W'(1);
        base_r <= base_end;
      end
      chk_vld_r <= cmd.chk;
      if (cfg_wr_en) begin
        limit_r <= limit_nxt;
      end
      if (cmd.out_ld) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_op_r  <= op_t'(in_tuser);
      req_cur_r <= in_tdata[FRAME_W-1:0];
      req_sup_r <= in_tdata[FRAME_W];
      req_wr_r  <= in_tdata[FRAME_W+1];
    end
    if (cmd.chk) begin
      chk_addr_r <= addr_r;
      chk_base_r <= base_r;
    end
    if (cmd.rd) begin
      bit_r <= bit_off[BW-1:0];
    end
    if (cmd.res_ld) begin
      res_status_r <= cmd.res_sel;
      case (cmd.res_sel)
        ST_ALLOC: begin
          res_frame_r    <= found_frame[FRAME_W-1:0];
          res_present_r  <= 1'b1;
          res_writable_r <= req_wr_r;
          res_user_r     <= ~req_sup_r;
        end
        ST_NOOP: begin
          res_frame_r    <= (req_op_r == OP_ALLOC) ? req_cur_r : '0;
          res_present_r  <= 1'b0;
          res_writable_r <= 1'b0;
          res_user_r     <= 1'b0;
        end
        default: begin
          res_frame_r    <= '0;
          res_present_r  <= 1'b0;
          res_writable_r <= 1'b0;
          res_user_r     <= 1'b0;
        end
      endcase
    end
    if (cmd.out_ld) begin
      out_frame_r    <= res_frame_r;
      out_present_r  <= res_present_r;
      out_writable_r <= res_writable_r;
      out_user_r     <= res_user_r;
      out_status_r   <= res_status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_user_r, out_writable_r, out_present_r,
                       out_frame_r};
  assign out_tuser  = out_status_r;

endmodule

@@ design/bitmap_frame_allocator.sv @@
// top level of the first-fit bitmap frame allocator
//
//  channel | direction | payload
//  cfg_    | in        | cfg_wr_data: frame_count
//  in_     | in        | tdata: current_frame, is_supervisor, is_writable; tuser: op
//  out_    | out       | tdata: frame, present, writable, user_access; tuser: status
//
// one request at a time; allocate scans the words below frame_count from word 0,
// one bitmap ram read a cycle, up to the first word with a clear bit, and reports
// full when they are all full; free of a frame in word k steps up to word k first
// after reset a clearing pass zeroes the MAX_FRAMES / WORD_BITS bitmap words (rounded up)
// with in_tready low; config writes are taken throughout
// a finished result waits in the output register while the next request is worked on
module bitmap_frame_allocator #(
  parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF,
  parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bfa_pkg::CFG_W-1:0]       cfg_wr_data,   // frame_count
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bfa_pkg::IN_DATA_W-1:0]   in_tdata,      // current_frame, is_supervisor, is_writable
  input  logic                            in_tuser,      // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bfa_pkg::OUT_DATA_W-1:0]  out_tdata,     // frame, present, writable, user_access
  output logic [bfa_pkg::STATUS_W-1:0]    out_tuser      // status
);
  import bfa_pkg::*;

  bfa_cmd_t  cmd;
  bfa_stat_t st;

  bfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  bfa_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cmd         (cmd),
    .st          (st)
  );

endmodule

@@ design/bfa_checker.sv @@
// port-level checker for the frame allocator, bound to the top level
module bfa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bfa_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [bfa_pkg::STATUS_W-1:0]    out_tuser
);
  import bfa_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // only a fresh allocation carries page flags
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_ALLOC) |-> out_tdata[FRAME_W+2:FRAME_W] == 3'b000)
    else $error("page flags set on non-allocation result");

  // freed and full results report no frame
  a_zero_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FREED || out_tuser == ST_FULL)
      |-> out_tdata[FRAME_W-1:0] == '0)
    else $error("frame nonzero on freed or full result");

  // one request in flight
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in flight");

  // clearing pass blocks requests after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ready or valid straight after reset");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
